@@ src/tlfq_pkg.sv @@
// types and constants shared by the two-level feedback queue scheduler
`timescale 1ns / 1ps
package tlfq_pkg;

  typedef enum logic [1:0] {
    OP_ENQ_FAST       = 2'd0,
    OP_ENQ_SLOW_TAIL  = 2'd1,
    OP_ENQ_SLOW_FRONT = 2'd2,
    OP_PICK           = 2'd3
  } tlfq_op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_PRIO = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } tlfq_status_e;

  localparam int unsigned PidxW  = 6;
  localparam int unsigned PrioW  = 3;
  localparam int unsigned QuantW = 4;

  localparam logic CFG_FAST_QUANTUM = 1'b0;
  localparam logic CFG_SLOW_QUANTUM = 1'b1;

  localparam logic [QuantW-1:0] FAST_QUANTUM_RST = 4'd2;
  localparam logic [QuantW-1:0] SLOW_QUANTUM_RST = 4'd4;

  typedef struct packed {
    tlfq_op_e          op;
    logic [PidxW-1:0]  process_index;
    logic [PrioW-1:0]  priority_req;
  } tlfq_cmd_t;

  typedef struct packed {
    tlfq_status_e      status;
    logic [PidxW-1:0]  chosen_index;
    logic              chosen_level;
    logic [QuantW-1:0] quantum_assigned;
    logic              fast_queue_busy;
  } tlfq_res_t;

endpackage

@@ src/two_level_feedback_queue_scheduler.sv @@
// two-level feedback ready-queue scheduler with one fast queue and static-priority slow groups
// a command is held in the command register, and its result then in the result register
// throughput: one command per cycle, busy_o stays low; each command makes at most one queue store access
// results cannot be stalled; a pick reads the head entry through a registered read port
// reset clears heads and counts and loads default quanta; store stays undefined until written
`timescale 1ns / 1ps
module two_level_feedback_queue_scheduler #(
  parameter int unsigned MAX_PROCESSES   = 64,
  parameter int unsigned PRIORITY_GROUPS = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  tlfq_pkg::tlfq_cmd_t             cmd_i,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [tlfq_pkg::QuantW-1:0]     cfg_data_i,
  output logic                            done_o,
  output tlfq_pkg::tlfq_res_t             res_o
);

  localparam int unsigned NumQ    = PRIORITY_GROUPS + 1;
  localparam int unsigned QW      = $clog2(NumQ);
  localparam int unsigned PW      = $clog2(MAX_PROCESSES);
  localparam int unsigned CW      = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned AW      = QW + PW;
  localparam int unsigned MemDepth = NumQ * (2 ** PW);

  localparam logic [PW:0]   MaxSum  = (PW+1)'(MAX_PROCESSES);
  localparam logic [PW-1:0] LastPos = PW'(MAX_PROCESSES - 1);
  localparam logic [CW-1:0] MaxCnt  = CW'(MAX_PROCESSES);

  // configuration
  logic [tlfq_pkg::QuantW-1:0] fast_quant_q, slow_quant_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_quant_q <= tlfq_pkg::FAST_QUANTUM_RST;
      slow_quant_q <= tlfq_pkg::SLOW_QUANTUM_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tlfq_pkg::CFG_FAST_QUANTUM: fast_quant_q <= cfg_data_i;
        tlfq_pkg::CFG_SLOW_QUANTUM: slow_quant_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // command register
  logic                start_xfer;
  logic                req_valid_q;
  tlfq_pkg::tlfq_cmd_t req_q;

  assign busy_o     = 1'b0;
  assign start_xfer = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_xfer) begin
      req_q <= cmd_i;
    end
  end

  // queue bookkeeping
  logic [PW-1:0] head_q [NumQ];
  logic [CW-1:0] cnt_q  [NumQ];

  logic          prio_ok;
  logic [QW-1:0] prio_sel;
  logic [QW-1:0] pick_sel;
  logic          pick_found;
  logic [QW-1:0] sel;
  logic [PW-1:0] head_sel;
  logic [CW-1:0] cnt_sel;
  logic          full;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] tail_pos;
  logic [PW-1:0] front_pos;
  logic [PW-1:0] next_head;

  logic          upd;
  logic [PW-1:0] head_d;
  logic [CW-1:0] cnt_d;
  logic          mem_we, mem_re;
  logic [PW-1:0] mem_pos;
  logic [CW-1:0] cnt0_after;

  tlfq_pkg::tlfq_status_e      status_d;
  logic [tlfq_pkg::QuantW-1:0] quant_d;
  logic                        level_d;

  assign prio_ok  = (32'(req_q.priority_req) >= 32'd1) &&
                    (32'(req_q.priority_req) <= PRIORITY_GROUPS);
  assign prio_sel = prio_ok ? QW'(req_q.priority_req) : '0;

  always_comb begin
    pick_sel   = '0;
    pick_found = 1'b0;
    for (int unsigned i = 1; i < NumQ; i++) begin
      if (cnt_q[i] != '0) begin
        pick_sel   = QW'(i);
        pick_found = 1'b1;
      end
    end
    if (cnt_q[0] != '0) begin
      pick_sel   = '0;
      pick_found = 1'b1;
    end
  end

  always_comb begin
    unique case (req_q.op)
      tlfq_pkg::OP_ENQ_FAST: sel = '0;
      tlfq_pkg::OP_PICK:     sel = pick_sel;
      default:               sel = prio_sel;
    endcase
  end

  assign head_sel  = head_q[sel];
  assign cnt_sel   = cnt_q[sel];
  assign full      = (cnt_sel == MaxCnt);
  assign tail_sum  = (PW+1)'(head_sel) + (PW+1)'(cnt_sel);
  assign tail_pos  = (tail_sum >= MaxSum) ? PW'(tail_sum - MaxSum) : PW'(tail_sum);
  assign front_pos = (head_sel == '0) ? LastPos : head_sel - PW'(1);
  assign next_head = (head_sel == LastPos) ? '0 : head_sel + PW'(1);

  always_comb begin
    upd      = 1'b0;
    head_d   = head_sel;
    cnt_d    = cnt_sel;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_pos  = tail_pos;
    status_d = tlfq_pkg::ST_OK;
    quant_d  = '0;
    level_d  = 1'b0;
    unique case (req_q.op)
      tlfq_pkg::OP_ENQ_FAST: begin
        if (full) begin
          status_d = tlfq_pkg::ST_FULL;
        end else begin
          upd     = 1'b1;
          mem_we  = 1'b1;
          cnt_d   = cnt_sel + CW'(1);
          quant_d = fast_quant_q;
        end
      end
      tlfq_pkg::OP_ENQ_SLOW_TAIL: begin
        if (!prio_ok) begin
          status_d = tlfq_pkg::ST_BAD_PRIO;
        end else if (full) begin
          status_d = tlfq_pkg::ST_FULL;
        end else begin
          upd     = 1'b1;
          mem_we  = 1'b1;
          cnt_d   = cnt_sel + CW'(1);
          quant_d = slow_quant_q;
        end
      end
      tlfq_pkg::OP_ENQ_SLOW_FRONT: begin
        if (!prio_ok) begin
          status_d = tlfq_pkg::ST_BAD_PRIO;
        end else if (full) begin
          status_d = tlfq_pkg::ST_FULL;
        end else begin
          upd     = 1'b1;
          mem_we  = 1'b1;
          mem_pos = front_pos;
          head_d  = front_pos;
          cnt_d   = cnt_sel + CW'(1);
        end
      end
      tlfq_pkg::OP_PICK: begin
        if (!pick_found) begin
          status_d = tlfq_pkg::ST_EMPTY;
        end else begin
          upd     = 1'b1;
          mem_re  = 1'b1;
          mem_pos = head_sel;
          head_d  = next_head;
          cnt_d   = cnt_sel - CW'(1);
          level_d = (sel != '0);
        end
      end
      default: ;
    endcase
  end

  assign cnt0_after = (req_valid_q && upd && sel == '0) ? cnt_d : cnt_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < NumQ; i++) begin
        head_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (req_valid_q && upd) begin
      head_q[sel] <= head_d;
      cnt_q[sel]  <= cnt_d;
    end
  end

  // queue store
  logic [tlfq_pkg::PidxW-1:0] queue_store_q [MemDepth];
  logic [tlfq_pkg::PidxW-1:0] rd_data_q;
  logic [AW-1:0]              mem_addr;

  assign mem_addr = {sel, mem_pos};

  always_ff @(posedge clk_i) begin
    if (req_valid_q && mem_we) begin
      queue_store_q[mem_addr] <= req_q.process_index;
    end
    if (req_valid_q && mem_re) begin
      rd_data_q <= queue_store_q[mem_addr];
    end
  end

  // result register
  logic                        res_valid_q;
  tlfq_pkg::tlfq_status_e      status_q;
  logic [tlfq_pkg::QuantW-1:0] quant_q;
  logic                        level_q;
  logic                        popped_q;
  logic                        fast_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_q) begin
      status_q    <= status_d;
      quant_q     <= quant_d;
      level_q     <= level_d;
      popped_q    <= mem_re;
      fast_busy_q <= (cnt0_after != '0);
    end
  end

  assign done_o                 = res_valid_q;
  assign res_o.status           = status_q;
  assign res_o.chosen_index     = popped_q ? rd_data_q : '0;
  assign res_o.chosen_level     = level_q;
  assign res_o.quantum_assigned = quant_q;
  assign res_o.fast_queue_busy  = fast_busy_q;

  // checks
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q |=> res_valid_q)
    else $error("result strobe missing after command");

  a_fast_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= MaxCnt)
    else $error("fast queue count above capacity");

  a_fast_busy_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_o.fast_queue_busy == (cnt_q[0] != '0)))
    else $error("fast queue busy flag disagrees with count");

  a_pick_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && req_q.op == tlfq_pkg::OP_PICK && cnt_q[0] != '0) |=>
      (res_o.status == tlfq_pkg::ST_OK && !res_o.chosen_level))
    else $error("pick skipped a non-empty fast queue");

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the two-level feedback queue scheduler
`timescale 1ns / 1ps
module testbench;

  localparam int NUM_LEVELS  = 6;
  localparam int QUEUE_DEPTH = 64;
  localparam int TOP_PRIO    = 5;
  localparam int FILL_LEN    = QUEUE_DEPTH + 2;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  tlfq_pkg::tlfq_cmd_t         cmd_i;
  logic                        cfg_we_i;
  logic                        cfg_idx_i;
  logic [tlfq_pkg::QuantW-1:0] cfg_data_i;
  logic                        done_o;
  tlfq_pkg::tlfq_res_t         res_o;

  two_level_feedback_queue_scheduler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .res_o      (res_o)
  );

  // predictor copy of the ready queues and quanta
  logic [tlfq_pkg::PidxW-1:0]  ready_mem  [NUM_LEVELS][QUEUE_DEPTH];
  logic [tlfq_pkg::PidxW-1:0]  ready_head [NUM_LEVELS];
  logic [tlfq_pkg::PidxW:0]    ready_cnt  [NUM_LEVELS];
  logic [tlfq_pkg::QuantW-1:0] fast_quantum;
  logic [tlfq_pkg::QuantW-1:0] slow_quantum;

  tlfq_pkg::tlfq_cmd_t pending_cmds [$];
  tlfq_pkg::tlfq_res_t expected_res [$];
  tlfq_pkg::tlfq_res_t res_want;
  int                  sender_idle_pct;
  int                  fail_count;
  int                  cmds_sent;
  int                  status_seen [4];

  function automatic tlfq_pkg::tlfq_res_t predict_schedule(tlfq_pkg::tlfq_cmd_t c);
    tlfq_pkg::tlfq_res_t        r;
    logic [2:0]                 lvl;
    logic [tlfq_pkg::PidxW-1:0] pos;
    int                         k;
    r = '0;
    r.status = tlfq_pkg::ST_OK;
    case (c.op)
      tlfq_pkg::OP_ENQ_FAST: begin
        if (ready_cnt[0] == QUEUE_DEPTH) begin
          r.status = tlfq_pkg::ST_FULL;
        end else begin
          pos = ready_head[0] + ready_cnt[0][tlfq_pkg::PidxW-1:0];
          ready_mem[0][pos] = c.process_index;
          ready_cnt[0] = ready_cnt[0] + 1'b1;
          r.quantum_assigned = fast_quantum;
        end
      end
      tlfq_pkg::OP_ENQ_SLOW_TAIL, tlfq_pkg::OP_ENQ_SLOW_FRONT: begin
        lvl = c.priority_req;
        if (lvl == 0 || lvl > TOP_PRIO) begin
          r.status = tlfq_pkg::ST_BAD_PRIO;
        end else if (ready_cnt[lvl] == QUEUE_DEPTH) begin
          r.status = tlfq_pkg::ST_FULL;
        end else if (c.op == tlfq_pkg::OP_ENQ_SLOW_TAIL) begin
          pos = ready_head[lvl] + ready_cnt[lvl][tlfq_pkg::PidxW-1:0];
          ready_mem[lvl][pos] = c.process_index;
          ready_cnt[lvl] = ready_cnt[lvl] + 1'b1;
          r.quantum_assigned = slow_quantum;
        end else begin
          ready_head[lvl] = ready_head[lvl] - 1'b1;
          ready_mem[lvl][ready_head[lvl]] = c.process_index;
          ready_cnt[lvl] = ready_cnt[lvl] + 1'b1;
        end
      end
      default: begin
        r.status = tlfq_pkg::ST_EMPTY;
        // fast queue first, then groups from highest priority down
        for (k = 0; k < NUM_LEVELS; k++) begin
          lvl = (k == 0) ? 3'd0 : 3'(NUM_LEVELS - k);
          if (r.status == tlfq_pkg::ST_EMPTY && ready_cnt[lvl] != 0) begin
            r.chosen_index = ready_mem[lvl][ready_head[lvl]];
            r.chosen_level = (lvl != 0);
            ready_head[lvl] = ready_head[lvl] + 1'b1;
            ready_cnt[lvl] = ready_cnt[lvl] - 1'b1;
            r.status = tlfq_pkg::ST_OK;
          end
        end
      end
    endcase
    r.fast_queue_busy = (ready_cnt[0] != 0);
    return r;
  endfunction

  task automatic add_cmd(tlfq_pkg::tlfq_op_e op, int idx, int prio);
    tlfq_pkg::tlfq_cmd_t c;
    c.op = op;
    c.process_index = tlfq_pkg::PidxW'(idx);
    c.priority_req = tlfq_pkg::PrioW'(prio);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic add_random(int n, int pick_pct);
    int                  sel;
    int                  prio;
    tlfq_pkg::tlfq_op_e  op;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < pick_pct) op = tlfq_pkg::OP_PICK;
      else if (sel < pick_pct + (100 - pick_pct) * 2 / 5) op = tlfq_pkg::OP_ENQ_FAST;
      else if (sel < pick_pct + (100 - pick_pct) * 7 / 10) op = tlfq_pkg::OP_ENQ_SLOW_TAIL;
      else op = tlfq_pkg::OP_ENQ_SLOW_FRONT;
      prio = ($urandom_range(99) < 85) ? $urandom_range(TOP_PRIO, 1) : $urandom_range(7);
      add_cmd(op, $urandom_range(63), prio);
    end
  endtask

  // overfill one level so that the last enqueues hit a full queue
  task automatic add_fill(int lvl);
    for (int i = 0; i < FILL_LEN; i++) begin
      if (lvl == 0) add_cmd(tlfq_pkg::OP_ENQ_FAST, $urandom_range(63), $urandom_range(7));
      else add_cmd($urandom_range(1) ? tlfq_pkg::OP_ENQ_SLOW_TAIL : tlfq_pkg::OP_ENQ_SLOW_FRONT,
                   $urandom_range(63), lvl);
    end
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start_i || expected_res.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_quanta(logic [tlfq_pkg::QuantW-1:0] fast_val,
                            logic [tlfq_pkg::QuantW-1:0] slow_val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= tlfq_pkg::CFG_FAST_QUANTUM;
    cfg_data_i <= fast_val;
    @(posedge clk_i);
    cfg_idx_i  <= tlfq_pkg::CFG_SLOW_QUANTUM;
    cfg_data_i <= slow_val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    fast_quantum = fast_val;
    slow_quantum = slow_val;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (!start_i || !busy_o) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        start_i <= 1'b1;
        cmd_i   <= pending_cmds[0];
        pending_cmds.delete(0);
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        expected_res.insert(expected_res.size(), predict_schedule(cmd_i));
        cmds_sent++;
      end
      if (done_o === 1'b1) begin
        if (expected_res.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          res_want = expected_res[0];
          expected_res.delete(0);
          status_seen[res_o.status]++;
          if (res_o.status !== res_want.status) begin
            $error("status: expected %0d, actual %0d", res_want.status, res_o.status);
            fail_count++;
          end
          if (res_o.chosen_index !== res_want.chosen_index) begin
            $error("chosen_index: expected %0d, actual %0d",
                   res_want.chosen_index, res_o.chosen_index);
            fail_count++;
          end
          if (res_o.chosen_level !== res_want.chosen_level) begin
            $error("chosen_level: expected %0d, actual %0d",
                   res_want.chosen_level, res_o.chosen_level);
            fail_count++;
          end
          if (res_o.quantum_assigned !== res_want.quantum_assigned) begin
            $error("quantum_assigned: expected %0d, actual %0d",
                   res_want.quantum_assigned, res_o.quantum_assigned);
            fail_count++;
          end
          if (res_o.fast_queue_busy !== res_want.fast_queue_busy) begin
            $error("fast_queue_busy: expected %0d, actual %0d",
                   res_want.fast_queue_busy, res_o.fast_queue_busy);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    cmd_i           = '0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = tlfq_pkg::CFG_FAST_QUANTUM;
    cfg_data_i      = '0;
    sender_idle_pct = 32;
    fail_count      = 0;
    cmds_sent       = 0;
    fast_quantum    = tlfq_pkg::FAST_QUANTUM_RST;
    slow_quantum    = tlfq_pkg::SLOW_QUANTUM_RST;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      ready_head[i] = '0;
      ready_cnt[i]  = '0;
    end
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pick, field extremes, bad priorities, pick order
    add_cmd(tlfq_pkg::OP_PICK, 63, 7);
    add_cmd(tlfq_pkg::OP_ENQ_FAST, 63, 7);
    add_cmd(tlfq_pkg::OP_ENQ_FAST, 0, 0);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_TAIL, 21, 1);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_TAIL, 42, TOP_PRIO);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_FRONT, 63, TOP_PRIO);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_FRONT, 0, 3);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_TAIL, 10, 0);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_FRONT, 11, 6);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_TAIL, 12, 7);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_FRONT, 13, 0);
    repeat (7) add_cmd(tlfq_pkg::OP_PICK, 0, 0);
    add_cmd(tlfq_pkg::OP_ENQ_SLOW_TAIL, 45, 2);
    add_cmd(tlfq_pkg::OP_PICK, 0, 0);
    wait_drained();

    set_quanta(4'd15, 4'd1);
    add_random(70, 30);
    add_fill(0);
    add_random(40, 60);
    wait_drained();

    sender_idle_pct = 75;
    set_quanta(4'd0, 4'd15);
    add_fill(TOP_PRIO);
    add_random(70, 35);
    wait_drained();

    sender_idle_pct = 0;
    set_quanta(4'd1, 4'd0);
    add_random(50, 40);
    wait_drained();
    add_fill(1);
    add_random(50, 55);
    wait_drained();

    if (expected_res.size() != 0) begin
      $error("results outstanding at end: expected %0d, actual %0d", 0, expected_res.size());
      fail_count++;
    end

    $display("tb: %0d commands transferred, results ok %0d, bad priority %0d,",
             cmds_sent, status_seen[tlfq_pkg::ST_OK], status_seen[tlfq_pkg::ST_BAD_PRIO]);
    $display("tb: queue full %0d, nothing ready %0d, over four quantum settings",
             status_seen[tlfq_pkg::ST_FULL], status_seen[tlfq_pkg::ST_EMPTY]);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ two_level_feedback_queue_scheduler.f @@
src/tlfq_pkg.sv
src/two_level_feedback_queue_scheduler.sv
verif/testbench.sv
